// ===== rtl/core/cst_pkg.sv =====
// Shared types, command and status codes for the semaphore table.
package cst_pkg;

    localparam int SemCountDef  = 64;
    localparam int ProcCountDef = 32;

    typedef logic [2:0] t_cmd;
    typedef logic [2:0] t_status;

    localparam t_cmd CMD_CREATE   = 3'd0;
    localparam t_cmd CMD_DELETE   = 3'd1;
    localparam t_cmd CMD_SIGNAL   = 3'd2;
    localparam t_cmd CMD_SIGNAL_N = 3'd3;
    localparam t_cmd CMD_RESET    = 3'd4;
    localparam t_cmd CMD_TRY_WAIT = 3'd5;
    localparam t_cmd CMD_WAIT     = 3'd6;
    localparam t_cmd CMD_QUERY    = 3'd7;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_BAD_ARG  = 3'd1;
    localparam t_status ST_OVERFLOW = 3'd2;
    localparam t_status ST_WOULD_BLK = 3'd3;
    localparam t_status ST_BLOCKED  = 3'd4;

    localparam logic signed [16:0] ValMax = 17'sd32767;
    localparam logic signed [16:0] ValMin = -17'sd32768;

endpackage

// ===== rtl/core/cst_queue.sv =====
// Wait queue store: per-semaphore head, tail and empty flag plus the link table.
module cst_queue #(
    parameter int SEM_COUNT  = cst_pkg::SemCountDef,
    parameter int PROC_COUNT = cst_pkg::ProcCountDef,
    localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1,
    localparam int PW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [SW-1:0] i_sem,
    input  logic          i_load,
    input  logic          i_push,
    input  logic [PW-1:0] i_push_pid,
    input  logic          i_pop,
    input  logic          i_clear,
    output logic          o_empty,
    output logic [PW-1:0] o_head
);
    import cst_pkg::*;

    logic [PW-1:0] r_head [SEM_COUNT];
    logic [PW-1:0] r_tail [SEM_COUNT];
    logic [PW-1:0] r_next [PROC_COUNT];
    logic [SEM_COUNT-1:0] r_empty;
    // Working copies of the selected semaphore's head and tail.
    logic [PW-1:0] r_hd;
    logic [PW-1:0] r_tl;

    assign o_empty = r_empty[i_sem];
    assign o_head  = r_hd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty <= '1;
        end else if (i_clear) begin
            r_empty[i_sem] <= 1'b1;
        end else if (i_push) begin
            r_empty[i_sem] <= 1'b0;
        end else if (i_pop && !r_empty[i_sem] && r_hd == r_tl) begin
            r_empty[i_sem] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hd <= r_head[i_sem];
            r_tl <= r_tail[i_sem];
        end else if (i_push) begin
            r_tail[i_sem] <= i_push_pid;
            r_tl <= i_push_pid;
            if (r_empty[i_sem]) begin
                r_head[i_sem] <= i_push_pid;
                r_hd <= i_push_pid;
            end else begin
                r_next[r_tl] <= i_push_pid;
            end
        end else if (i_pop && !r_empty[i_sem] && r_hd != r_tl) begin
            r_head[i_sem] <= r_next[r_hd];
            r_hd <= r_next[r_hd];
        end
    end
endmodule

// ===== rtl/core/counting_semaphore_table.sv =====
// Top level of the counting semaphore table with FIFO wait queues.
// A command is taken in the idle state; the read state loads its value and queue
// pointers, and the exec state executes it and registers its status word, waiting
// while the output stalls. Delete, reset and a signal or signal_n that does not
// overflow then go through the wake state, which sends one word per wake (up to
// PROC_COUNT) and a final word. Only one command is handled at a time. Reset clears
// the live flags, empties every queue and zeroes the next id; values and links
// are undefined until written.
module counting_semaphore_table #(
    parameter int SEM_COUNT  = cst_pkg::SemCountDef,
    parameter int PROC_COUNT = cst_pkg::ProcCountDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cst_pkg::t_cmd       i_command,
    input  logic [5:0]          i_sem_id,
    input  logic [14:0]         i_amount,
    input  logic [4:0]          i_caller_pid,
    output logic                o_valid,
    input  logic                i_stall,
    output cst_pkg::t_status    o_status,
    output logic signed [15:0]  o_value,
    output logic                o_wake_valid,
    output logic [4:0]          o_wake_pid,
    output logic                o_last
);
    import cst_pkg::*;

    localparam int SW = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int PW = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
    localparam int CW = $clog2(PROC_COUNT + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WAKE = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    logic [1:0]  r_state;
    t_cmd        r_cmd;
    logic [5:0]  r_sem;
    logic [14:0] r_amt;
    logic [4:0]  r_pid;
    logic [15:0] r_wakes;
    logic [CW-1:0] r_cnt;
    logic [6:0]  r_next_id;
    logic [SEM_COUNT-1:0] r_live;
    logic signed [15:0] r_val [SEM_COUNT];
    logic signed [15:0] r_cur;

    logic          r_ovalid;
    t_status       r_ostatus;
    logic [15:0]   r_ovalue;
    logic          r_owake;
    logic [4:0]    r_opid;
    logic          r_olast;

    logic [SW-1:0] sem_idx;
    logic          q_empty, q_push, q_pop, q_clear, q_load;
    logic [PW-1:0] q_head;
    logic          out_free;
    logic          id_ok;
    logic signed [16:0] cur, sum;

    assign sem_idx  = (r_cmd == CMD_CREATE) ? r_next_id[SW-1:0] : r_sem[SW-1:0];
    assign out_free = !r_ovalid || !i_stall;
    assign id_ok    = ({1'b0, r_sem} < 7'(SEM_COUNT)) && r_live[sem_idx];
    assign cur      = 17'(r_cur);
    // One shared adder: +1, +amount, -1 as the command needs.
    always_comb begin
        case (r_cmd)
            CMD_SIGNAL:   sum = cur + 17'sd1;
            CMD_SIGNAL_N: sum = cur + $signed({2'b0, r_amt});
            default:      sum = cur - 17'sd1;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);
    assign q_load  = (r_state == S_READ);
    assign q_push  = (r_state == S_EXEC) && out_free && r_cmd == CMD_WAIT && id_ok
                   && {1'b0, r_pid} < 6'(PROC_COUNT) && cur != ValMin && sum < 0;
    assign q_pop   = (r_state == S_WAKE) && out_free && !q_empty
                   && r_cnt < CW'(PROC_COUNT) && 16'(r_cnt) < r_wakes;
    assign q_clear = (r_state == S_WAKE) && out_free
                   && !(!q_empty && r_cnt < CW'(PROC_COUNT) && 16'(r_cnt) < r_wakes)
                   && (r_cmd == CMD_DELETE || r_cmd == CMD_RESET)
                   || (r_state == S_EXEC) && out_free && r_cmd == CMD_CREATE
                   && r_next_id < 7'(SEM_COUNT);

    cst_queue #(.SEM_COUNT(SEM_COUNT), .PROC_COUNT(PROC_COUNT)) u_queue (
        .i_clk, .i_rst_n, .i_sem(sem_idx), .i_load(q_load), .i_push(q_push),
        .i_push_pid(r_pid[PW-1:0]), .i_pop(q_pop), .i_clear(q_clear),
        .o_empty(q_empty), .o_head(q_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_live    <= '0;
            r_next_id <= '0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_command; r_sem <= i_sem_id;
                        r_amt <= i_amount;  r_pid <= i_caller_pid;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_cur <= r_val[sem_idx];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1; r_ostatus <= ST_OK; r_ovalue <= '0;
                        r_owake <= 1'b0; r_opid <= '0; r_olast <= 1'b1;
                        r_cnt <= '0; r_state <= S_IDLE;
                        if (r_cmd == CMD_CREATE) begin
                            if (r_next_id >= 7'(SEM_COUNT)) begin
                                r_ostatus <= ST_BAD_ARG;
                            end else begin
                                r_next_id <= r_next_id + 7'd1;
                                r_val[sem_idx] <= $signed({1'b0, r_amt});
                                r_live[sem_idx] <= 1'b1;
                                r_ovalue <= 16'(r_next_id);
                            end
                        end else if (!id_ok) begin
                            r_ostatus <= ST_BAD_ARG;
                        end else begin
                            case (r_cmd)
                                CMD_DELETE, CMD_RESET: begin
                                    r_ovalid <= 1'b0; r_wakes <= 16'hFFFF;
                                    r_state <= S_WAKE;
                                end
                                CMD_SIGNAL, CMD_SIGNAL_N: begin
                                    if (sum > ValMax) begin
                                        r_ostatus <= ST_OVERFLOW;
                                    end else begin
                                        r_val[sem_idx] <= sum[15:0];
                                        r_ovalid <= 1'b0; r_state <= S_WAKE;
                                        if (r_cmd == CMD_SIGNAL)
                                            r_wakes <= (sum <= 0) ? 16'd1 : 16'd0;
                                        else if (cur >= 0)
                                            r_wakes <= '0;
                                        else if (-cur < $signed({2'b0, r_amt}))
                                            r_wakes <= 16'(-cur);
                                        else
                                            r_wakes <= {1'b0, r_amt};
                                    end
                                end
                                CMD_TRY_WAIT: begin
                                    if (cur <= 0) r_ostatus <= ST_WOULD_BLK;
                                    else r_val[sem_idx] <= sum[15:0];
                                end
                                CMD_WAIT: begin
                                    if ({1'b0, r_pid} >= 6'(PROC_COUNT)) begin
                                        r_ostatus <= ST_BAD_ARG;
                                    end else if (cur == ValMin) begin
                                        r_ostatus <= ST_OVERFLOW;
                                    end else begin
                                        r_val[sem_idx] <= sum[15:0];
                                        if (sum < 0) r_ostatus <= ST_BLOCKED;
                                    end
                                end
                                default: r_ovalue <= cur[15:0];
                            endcase
                        end
                    end
                end
                S_WAKE: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1; r_ostatus <= ST_OK; r_ovalue <= '0;
                        if (q_pop) begin
                            r_owake <= 1'b1; r_opid <= 5'(q_head); r_olast <= 1'b0;
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_owake <= 1'b0; r_opid <= '0; r_olast <= 1'b1;
                            if (r_cmd == CMD_DELETE) r_live[sem_idx] <= 1'b0;
                            if (r_cmd == CMD_RESET)
                                r_val[sem_idx] <= $signed({1'b0, r_amt});
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_value      = r_ovalue;
    assign o_wake_valid = r_owake;
    assign o_wake_pid   = r_opid;
    assign o_last       = r_olast;
endmodule

// ===== tb/counting_semaphore_table_test.sv =====
// Self-checking testbench for the counting semaphore table.
module counting_semaphore_table_test;
    import cst_pkg::*;

    localparam int SemCount  = 64;
    localparam int ProcCount = 32;

    typedef struct packed {
        t_status            status;
        logic signed [15:0] value;
        logic               wake_valid;
        logic [4:0]         wake_pid;
        logic               last;
    } t_word;

    class sem_scoreboard;
        logic signed [15:0] count_tbl[SemCount];
        bit                 live_tbl[SemCount];
        logic [4:0]         waiters[SemCount][$];
        int                 next_sem;
        t_word              pending[$];
        int                 errors;

        function new();
            next_sem = 0;
            errors = 0;
            foreach (live_tbl[i]) begin
                live_tbl[i] = 0;
                count_tbl[i] = 0;
            end
        endfunction

        function void push_word(t_status st, logic signed [15:0] v, bit wv,
                                logic [4:0] pid, bit lst);
            t_word w;
            w.status = st;
            w.value = v;
            w.wake_valid = wv;
            w.wake_pid = pid;
            w.last = lst;
            pending.push_back(w);
        endfunction

        function void release_waiters(int s, int limit);
            int n;
            n = 0;
            while (n < limit && n < ProcCount && waiters[s].size() > 0) begin
                push_word(ST_OK, 0, 1, waiters[s].pop_front(), 0);
                n++;
            end
        endfunction

        function void note_command(t_cmd cmd, int s, int amt, int pid);
            int v;
            int wakes;
            if (cmd == CMD_CREATE) begin
                if (next_sem >= SemCount) begin
                    push_word(ST_BAD_ARG, 0, 0, 0, 1);
                    return;
                end
                count_tbl[next_sem] = 16'(amt);
                live_tbl[next_sem] = 1;
                waiters[next_sem].delete();
                push_word(ST_OK, 16'(next_sem), 0, 0, 1);
                next_sem++;
                return;
            end
            if (s >= SemCount || !live_tbl[s]) begin
                push_word(ST_BAD_ARG, 0, 0, 0, 1);
                return;
            end
            v = count_tbl[s];
            case (cmd)
                CMD_DELETE: begin
                    release_waiters(s, ProcCount);
                    waiters[s].delete();
                    live_tbl[s] = 0;
                    push_word(ST_OK, 0, 0, 0, 1);
                end
                CMD_SIGNAL: begin
                    if (v >= 32767) begin
                        push_word(ST_OVERFLOW, 0, 0, 0, 1);
                    end else begin
                        v++;
                        count_tbl[s] = 16'(v);
                        if (v <= 0) release_waiters(s, 1);
                        push_word(ST_OK, 0, 0, 0, 1);
                    end
                end
                CMD_SIGNAL_N: begin
                    if (v + amt > 32767) begin
                        push_word(ST_OVERFLOW, 0, 0, 0, 1);
                    end else begin
                        wakes = 0;
                        if (v < 0) wakes = (-v < amt) ? -v : amt;
                        count_tbl[s] = 16'(v + amt);
                        release_waiters(s, wakes);
                        push_word(ST_OK, 0, 0, 0, 1);
                    end
                end
                CMD_RESET: begin
                    release_waiters(s, ProcCount);
                    waiters[s].delete();
                    count_tbl[s] = 16'(amt);
                    push_word(ST_OK, 0, 0, 0, 1);
                end
                CMD_TRY_WAIT: begin
                    if (v <= 0) begin
                        push_word(ST_WOULD_BLK, 0, 0, 0, 1);
                    end else begin
                        count_tbl[s] = 16'(v - 1);
                        push_word(ST_OK, 0, 0, 0, 1);
                    end
                end
                CMD_WAIT: begin
                    if (pid >= ProcCount) begin
                        push_word(ST_BAD_ARG, 0, 0, 0, 1);
                    end else if (v <= -32768) begin
                        push_word(ST_OVERFLOW, 0, 0, 0, 1);
                    end else begin
                        v--;
                        count_tbl[s] = 16'(v);
                        if (v < 0) begin
                            waiters[s].push_back(5'(pid));
                            push_word(ST_BLOCKED, 0, 0, 0, 1);
                        end else begin
                            push_word(ST_OK, 0, 0, 0, 1);
                        end
                    end
                end
                default: push_word(ST_OK, 16'(v), 0, 0, 1);
            endcase
        endfunction

        function void check_word(t_word got);
            t_word exp_w;
            if (pending.size() == 0) begin
                $error("unexpected result word: status %0d", got.status);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.status !== exp_w.status) begin
                $error("status: expected %0d, got %0d", exp_w.status, got.status);
                errors++;
            end
            if (got.value !== exp_w.value) begin
                $error("value: expected %0d, got %0d", exp_w.value, got.value);
                errors++;
            end
            if (got.wake_valid !== exp_w.wake_valid) begin
                $error("wake_valid: expected %0d, got %0d", exp_w.wake_valid,
                       got.wake_valid);
                errors++;
            end
            if (got.wake_pid !== exp_w.wake_pid) begin
                $error("wake_pid: expected %0d, got %0d", exp_w.wake_pid, got.wake_pid);
                errors++;
            end
            if (got.last !== exp_w.last) begin
                $error("last: expected %0d, got %0d", exp_w.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    t_cmd               i_command;
    logic [5:0]         i_sem_id;
    logic [14:0]        i_amount;
    logic [4:0]         i_caller_pid;
    logic               o_valid;
    logic               i_stall;
    t_status            o_status;
    logic signed [15:0] o_value;
    logic               o_wake_valid;
    logic [4:0]         o_wake_pid;
    logic               o_last;

    sem_scoreboard sb;
    bit            long_hold;
    bit            stall_random;

    counting_semaphore_table dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("counting_semaphore_table_test: FAIL");
        $finish;
    end

    // Receiver: stall pattern of its own, plus a long hold-off when asked.
    initial begin
        t_word w;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall && i_rst_n) begin
                w.status = o_status;
                w.value = o_value;
                w.wake_valid = o_wake_valid;
                w.wake_pid = o_wake_pid;
                w.last = o_last;
                sb.check_word(w);
            end
            if (long_hold) i_stall <= 1'b1;
            else if (stall_random) i_stall <= ($urandom_range(0, 3) == 0);
            else i_stall <= 1'b0;
        end
    end

    int gap_left;
    int burst_left;

    // Offers one word, holding it until accepted; gaps come between bursts.
    task automatic send_word(t_cmd cmd, int s, int amt, int pid);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            while (gap_left > 0) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                gap_left--;
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_command <= cmd;
        i_sem_id <= 6'(s);
        i_amount <= 15'(amt);
        i_caller_pid <= 5'(pid);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_command(cmd, s, amt, pid);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly live ids; a small share addresses dead or unused ones.
    function automatic int pick_sem();
        if (sb.next_sem > 0 && $urandom_range(0, 9) != 0)
            return $urandom_range(0, sb.next_sem - 1);
        return $urandom_range(0, 63);
    endfunction

    function automatic int pick_amount();
        case ($urandom_range(0, 5))
            0: return 32767;
            1: return 0;
            2: return $urandom_range(0, 32767);
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    initial begin
        int  s;
        t_cmd c;
        sb = new();
        long_hold = 0;
        stall_random = 0;
        burst_left = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= CMD_CREATE;
        i_sem_id <= '0;
        i_amount <= '0;
        i_caller_pid <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bad id before any create, extremes, all commands.
        send_word(CMD_QUERY, 0, 0, 0);
        send_word(CMD_CREATE, 0, 32767, 0);
        send_word(CMD_SIGNAL, 0, 0, 0);
        send_word(CMD_SIGNAL_N, 0, 1, 0);
        send_word(CMD_CREATE, 63, 0, 31);
        send_word(CMD_TRY_WAIT, 1, 0, 0);
        send_word(CMD_WAIT, 1, 0, 31);
        send_word(CMD_WAIT, 1, 0, 0);
        send_word(CMD_WAIT, 1, 0, 21);
        send_word(CMD_QUERY, 1, 0, 0);
        send_word(CMD_SIGNAL, 1, 0, 0);
        send_word(CMD_SIGNAL_N, 1, 32767, 10);
        send_word(CMD_WAIT, 1, 0, 5);
        send_word(CMD_WAIT, 1, 0, 10);
        send_word(CMD_TRY_WAIT, 1, 0, 0);
        send_word(CMD_RESET, 1, 0, 0);
        send_word(CMD_RESET, 0, 0, 0);
        send_word(CMD_WAIT, 0, 0, 7);
        send_word(CMD_DELETE, 0, 0, 0);
        send_word(CMD_SIGNAL, 0, 0, 0);
        send_word(CMD_CREATE, 0, 21845, 0);
        send_word(CMD_QUERY, 2, 0, 0);
        send_word(CMD_TRY_WAIT, 2, 0, 0);

        // Top of range: reset a new semaphore to zero, signal it up to the maximum, then query it.
        stall_random = 1;
        send_word(CMD_CREATE, 0, 0, 0);
        send_word(CMD_RESET, 3, 0, 0);
        send_word(CMD_SIGNAL_N, 3, 32767, 0);
        send_word(CMD_QUERY, 3, 0, 0);

        // Long hold-off while commands keep coming.
        long_hold = 1;
        fork
            begin
                repeat (200) @(posedge i_clk);
                long_hold = 0;
            end
            for (int i = 0; i < 20; i++) send_word(CMD_WAIT, 1, 0, i);
        join
        send_word(CMD_DELETE, 1, 0, 0);

        for (int i = 0; i < 220; i++) begin
            stall_random = (i % 80) >= 20;
            s = pick_sem();
            c = t_cmd'($urandom_range(0, 7));
            if (c == CMD_CREATE && $urandom_range(0, 2) != 0) c = CMD_WAIT;
            if (c == CMD_WAIT && sb.live_tbl[s % SemCount]) begin
                // A process already blocked on any semaphore does not wait again.
                automatic int p = $urandom_range(0, 31);
                automatic bit dup = 0;
                foreach (sb.waiters[j, k]) if (sb.waiters[j][k] == p) dup = 1;
                if (!dup) send_word(c, s, $urandom_range(0, 32767), p);
            end else begin
                send_word(c, s, pick_amount(), $urandom_range(0, 31));
            end
        end
        // Exhaust the ids, then ask for one more.
        while (sb.next_sem < SemCount) send_word(CMD_CREATE, 0, pick_amount(), 0);
        send_word(CMD_CREATE, 0, pick_amount(), 0);
        go_idle();

        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("counting_semaphore_table_test: PASS");
        else
            $display("counting_semaphore_table_test: FAIL");
        $finish;
    end
endmodule
